@@ src/sbgc_pkg.sv @@
// Shared constants, entry layout and inter-module structs for the superblock allocator.
package sbgc_pkg;

  // Table geometry
  localparam int SB_COUNT    = 64;
  localparam int TYPE_COUNT  = 4;
  localparam int INVALID_MAX = 4095;

  localparam int SB_IDX_W = $clog2(SB_COUNT);
  localparam int CNT_W    = SB_IDX_W + 1;
  localparam int FREE_W   = 7;
  localparam int EC_W     = 20;
  localparam int INV_W    = 12;
  localparam int AMT_W    = 12;
  localparam int TYPE_W   = 2;
  localparam int MODE_W   = 3;
  localparam int THR_W    = 7;

  localparam logic [EC_W-1:0]  EC_MAX    = '1;
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(6);

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_ADD_INV   = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_MARK_FULL = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_OPEN      = MODE_W'(2);
  localparam logic [MODE_W-1:0] MODE_VICTIM    = MODE_W'(3);
  localparam logic [MODE_W-1:0] MODE_RECLAIM   = MODE_W'(4);

  // One superblock table entry
  typedef struct packed {
    logic [EC_W-1:0]   wear_cnt;
    logic              is_free;
    logic [TYPE_W-1:0] owner_type;
    logic              is_full;
    logic [INV_W-1:0]  invalid_sum;
  } sb_entry_t;

  localparam sb_entry_t SB_ENTRY_RESET = '{
    wear_cnt:    '0,
    is_free:     1'b1,
    owner_type:  '0,
    is_full:     1'b0,
    invalid_sum: '0
  };

  // Table access from the sequencer
  typedef struct packed {
    logic                rd_en;
    logic [SB_IDX_W-1:0] rd_addr;
    logic                wr_en;
    logic [SB_IDX_W-1:0] wr_addr;
    sb_entry_t           wr_data;
  } tbl_req_t;

  // Finished result handed to the output stage
  typedef struct packed {
    logic [SB_IDX_W-1:0] chosen_index;
    logic                found;
    logic [FREE_W-1:0]   free_left;
  } res_t;

endpackage

@@ src/sbgc_if.sv @@
// Handshake channel interfaces: operation input, result output and threshold write.
interface sbgc_in_if;
  import sbgc_pkg::*;
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [SB_IDX_W-1:0] sb_index;
  logic [AMT_W-1:0]    amount;
  logic [TYPE_W-1:0]   sb_type;

  modport source (output valid, mode, sb_index, amount, sb_type, input ready);
  modport sink   (input valid, mode, sb_index, amount, sb_type, output ready);
endinterface

interface sbgc_out_if;
  import sbgc_pkg::*;
  logic                valid;
  logic                ready;
  logic [SB_IDX_W-1:0] chosen_index;
  logic                found;
  logic                gc_needed;
  logic [FREE_W-1:0]   free_left;

  modport source (output valid, chosen_index, found, gc_needed, free_left, input ready);
  modport sink   (input valid, chosen_index, found, gc_needed, free_left, output ready);
endinterface

interface sbgc_cfg_if;
  import sbgc_pkg::*;
  logic             valid;
  logic             ready;
  logic [THR_W-1:0] gc_threshold;

  modport source (output valid, gc_threshold, input ready);
  modport sink   (input valid, gc_threshold, output ready);
endinterface

@@ src/sbgc_table.sv @@
// Superblock table: single-port-write, registered-read memory with per-entry valid bits.
module sbgc_table (
  input  logic               clk,
  input  logic               rst_n,
  input  sbgc_pkg::tbl_req_t req,
  output sbgc_pkg::sb_entry_t rd_data
);
  import sbgc_pkg::*;

  sb_entry_t           mem [SB_COUNT];
  logic [SB_COUNT-1:0] valid_r;
  sb_entry_t           rd_data_r;
  logic                rd_vld_r;

  // storage array, no reset
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  // valid bits: unwritten entries read as the reset entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r <= valid_r[req.rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : SB_ENTRY_RESET;

endmodule

@@ src/sbgc_ctrl.sv @@
// Sequencer: read-modify-write of one entry, or a full table scan for open and victim search.
module sbgc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  sbgc_in_if.sink             in_ch,
  output sbgc_pkg::res_t      res,
  output logic                res_vld,
  input  logic                res_rdy,
  output sbgc_pkg::tbl_req_t  tbl_req,
  input  sbgc_pkg::sb_entry_t tbl_rd
);
  import sbgc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_SCAN,
    S_COMMIT,
    S_DONE
  } state_t;

  state_t              state_r, state_nxt;
  logic [MODE_W-1:0]   mode_r;
  logic [SB_IDX_W-1:0] idx_r;
  logic [AMT_W-1:0]    amount_r;
  logic [TYPE_W-1:0]   type_r;
  logic [CNT_W-1:0]    issue_cnt_r;
  logic                cmp_vld_r;
  logic [SB_IDX_W-1:0] cmp_idx_r;
  logic                have_r;
  logic [SB_IDX_W-1:0] best_idx_r;
  logic [EC_W-1:0]     best_key_r;
  sb_entry_t           best_ent_r;
  logic [FREE_W-1:0]   free_total_r;
  logic [SB_IDX_W-1:0] res_chosen_r;
  logic                res_found_r;

  sb_entry_t           ent_mod;
  logic [INV_W:0]      inv_sum;
  logic                scan_open;
  logic                scan_hit;
  logic                scan_end;
  logic                have_upd;
  logic [EC_W-1:0]     scan_key;
  logic                issue_on;

  // entry update for single-entry operations
  always_comb begin
    ent_mod = tbl_rd;
    inv_sum = {1'b0, tbl_rd.invalid_sum} + {1'b0, amount_r};
    case (mode_r)
      MODE_ADD_INV: begin
        if (inv_sum > (INV_W+1)'(INVALID_MAX)) begin
          ent_mod.invalid_sum = INV_W'(INVALID_MAX);
        end else begin
          ent_mod.invalid_sum = inv_sum[INV_W-1:0];
        end
      end
      MODE_MARK_FULL: begin
        if (!tbl_rd.is_free) begin
          ent_mod.is_full = 1'b1;
        end
      end
      MODE_RECLAIM: begin
        if (!tbl_rd.is_free) begin
          if (tbl_rd.wear_cnt != EC_MAX) begin
            ent_mod.wear_cnt = tbl_rd.wear_cnt + EC_W'(1);
          end
          ent_mod.is_free     = 1'b1;
          ent_mod.is_full     = 1'b0;
          ent_mod.owner_type  = '0;
          ent_mod.invalid_sum = '0;
        end
      end
      default: ;
    endcase
  end

  // scan compare: least erase count among free, or most invalid among full in-use
  always_comb begin
    scan_open = (mode_r == MODE_OPEN);
    scan_key  = scan_open ? tbl_rd.wear_cnt : EC_W'(tbl_rd.invalid_sum);
    if (scan_open) begin
      scan_hit = cmp_vld_r && tbl_rd.is_free && (!have_r || (scan_key < best_key_r));
    end else begin
      scan_hit = cmp_vld_r && !tbl_rd.is_free && tbl_rd.is_full && (scan_key > best_key_r);
    end
    scan_end = cmp_vld_r && (cmp_idx_r == SB_IDX_W'(SB_COUNT - 1));
    have_upd = have_r || scan_hit;
    issue_on = (state_r == S_SCAN) && !issue_cnt_r[CNT_W-1];
  end

  // next state and table port
  always_comb begin
    state_nxt = state_r;
    tbl_req   = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          tbl_req.rd_en   = 1'b1;
          tbl_req.rd_addr = in_ch.sb_index;
          unique case (in_ch.mode) inside
            MODE_ADD_INV, MODE_MARK_FULL, MODE_RECLAIM: begin
              state_nxt = (int'(in_ch.sb_index) < SB_COUNT) ? S_MOD : S_DONE;
            end
            MODE_OPEN: begin
              state_nxt = (int'(in_ch.sb_type) < TYPE_COUNT) ? S_SCAN : S_DONE;
            end
            MODE_VICTIM: begin
              state_nxt = S_SCAN;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_MOD: begin
        tbl_req.wr_en   = 1'b1;
        tbl_req.wr_addr = idx_r;
        tbl_req.wr_data = ent_mod;
        state_nxt       = S_DONE;
      end
      S_SCAN: begin
        tbl_req.rd_en   = issue_on;
        tbl_req.rd_addr = issue_cnt_r[SB_IDX_W-1:0];
        if (scan_end) begin
          state_nxt = (scan_open && have_upd) ? S_COMMIT : S_DONE;
        end
      end
      S_COMMIT: begin
        tbl_req.wr_en              = 1'b1;
        tbl_req.wr_addr            = best_idx_r;
        tbl_req.wr_data            = best_ent_r;
        tbl_req.wr_data.is_free    = 1'b0;
        tbl_req.wr_data.is_full    = 1'b0;
        tbl_req.wr_data.owner_type = type_r;
        state_nxt                  = S_DONE;
      end
      S_DONE: begin
        if (res_rdy) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state, free count, scan tracking and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      free_total_r <= FREE_W'(SB_COUNT);
      cmp_vld_r    <= 1'b0;
      have_r       <= 1'b0;
      issue_cnt_r  <= '0;
    end else begin
      state_r   <= state_nxt;
      cmp_vld_r <= issue_on;
      cmp_idx_r <= issue_cnt_r[SB_IDX_W-1:0];
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            mode_r       <= in_ch.mode;
            idx_r        <= in_ch.sb_index;
            amount_r     <= in_ch.amount;
            type_r       <= in_ch.sb_type;
            issue_cnt_r  <= '0;
            have_r       <= 1'b0;
            best_idx_r   <= '0;
            best_key_r   <= '0;
            res_chosen_r <= in_ch.sb_index;
            res_found_r  <= 1'b0;
          end
        end
        S_MOD: begin
          if ((mode_r == MODE_RECLAIM) && !tbl_rd.is_free &&
              (free_total_r < FREE_W'(SB_COUNT))) begin
            free_total_r <= free_total_r + FREE_W'(1);
          end
        end
        S_SCAN: begin
          if (issue_on) begin
            issue_cnt_r <= issue_cnt_r + CNT_W'(1);
          end
          if (scan_hit) begin
            have_r     <= 1'b1;
            best_idx_r <= cmp_idx_r;
            best_key_r <= scan_key;
            best_ent_r <= tbl_rd;
          end
          if (scan_end && !scan_open) begin
            res_chosen_r <= scan_hit ? cmp_idx_r : best_idx_r;
            res_found_r  <= have_upd;
          end
        end
        S_COMMIT: begin
          res_chosen_r <= best_idx_r;
          res_found_r  <= 1'b1;
          if (free_total_r != '0) begin
            free_total_r <= free_total_r - FREE_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  assign in_ch.ready      = (state_r == S_IDLE);
  assign res_vld          = (state_r == S_DONE);
  assign res.chosen_index = res_chosen_r;
  assign res.found        = res_found_r;
  assign res.free_left    = free_total_r;

endmodule

@@ src/superblock_alloc_and_gc_victim_core.sv @@
// Single-entry ops (add/mark/reclaim) read the entry, write it back, then hand the result on;
// victim and open scan all 64 entries, and open then writes the chosen entry. One operation
// at a time: the next word is taken once the result has moved into the output register.
// The table memory's one read port, one entry per cycle, sets the scan length.
// Reset (rst_n, synchronous): all superblocks free and zeroed, free count 64, threshold 6;
// entry valid bits clear at once, so no clearing pass is needed.
module superblock_alloc_and_gc_victim_core (
  input  logic      clk,
  input  logic      rst_n,
  sbgc_in_if.sink   in_ch,
  sbgc_out_if.source out_ch,
  sbgc_cfg_if.sink  cfg_ch
);
  import sbgc_pkg::*;

  tbl_req_t            tbl_req;
  sb_entry_t           tbl_rd;
  res_t                res;
  logic                res_vld;
  logic                res_rdy;
  logic [THR_W-1:0]    gc_threshold_r;
  logic                out_valid_r;
  logic [SB_IDX_W-1:0] out_chosen_r;
  logic                out_found_r;
  logic                out_gc_r;
  logic [FREE_W-1:0]   out_free_r;

  sbgc_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (tbl_req),
    .rd_data (tbl_rd)
  );

  sbgc_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .res     (res),
    .res_vld (res_vld),
    .res_rdy (res_rdy),
    .tbl_req (tbl_req),
    .tbl_rd  (tbl_rd)
  );

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gc_threshold_r <= THR_RESET;
    end else if (cfg_ch.valid) begin
      gc_threshold_r <= cfg_ch.gc_threshold;
    end
  end

  assign cfg_ch.ready = 1'b1;

  // output register stage
  assign res_rdy = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (res_vld && res_rdy) begin
        out_valid_r  <= 1'b1;
        out_chosen_r <= res.chosen_index;
        out_found_r  <= res.found;
        out_free_r   <= res.free_left;
        out_gc_r     <= (res.free_left <= gc_threshold_r);
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.chosen_index = out_chosen_r;
  assign out_ch.found        = out_found_r;
  assign out_ch.gc_needed    = out_gc_r;
  assign out_ch.free_left    = out_free_r;

endmodule

@@ src/sbgc_checker.sv @@
// Port-level checks for the superblock allocator, bound to the top level.
module sbgc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [sbgc_pkg::SB_IDX_W-1:0] chosen_index,
  input logic                          found,
  input logic                          gc_needed,
  input logic [sbgc_pkg::FREE_W-1:0]   free_left,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input logic [sbgc_pkg::THR_W-1:0]    cfg_data
);
  import sbgc_pkg::*;

  logic [THR_W-1:0] thr_r;

  // shadow of the threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      thr_r <= cfg_data;
    end
  end

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(chosen_index) && $stable(found) &&
      $stable(gc_needed) && $stable(free_left))
    else $error("result word changed while stalled");

  // one operation in flight: no new word right after an accept
  a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again while an operation is in flight");

  // free count never exceeds the table size
  a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (free_left <= FREE_W'(SB_COUNT)))
    else $error("free count beyond table size");

  // gc flag agrees with the free count and the programmed threshold
  a_gc_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (gc_needed == (free_left <= thr_r)))
    else $error("gc_needed disagrees with free count and threshold");

endmodule

bind superblock_alloc_and_gc_victim_core sbgc_checker u_sbgc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .chosen_index (out_ch.chosen_index),
  .found        (out_ch.found),
  .gc_needed    (out_ch.gc_needed),
  .free_left    (out_ch.free_left),
  .cfg_valid    (cfg_ch.valid),
  .cfg_ready    (cfg_ch.ready),
  .cfg_data     (cfg_ch.gc_threshold)
);

@@ bench/superblock_alloc_and_gc_victim_core_test.sv @@
// Self-checking bench for the superblock allocator and GC victim picker.
`timescale 1ns / 1ps

module superblock_alloc_and_gc_victim_core_test;
  import sbgc_pkg::*;

  // Tracks the superblock table, predicts each result word and checks it in order
  class sbgc_scoreboard;
    typedef struct packed {
      logic [SB_IDX_W-1:0] chosen;
      logic                found;
      logic                gc;
      logic [FREE_W-1:0]   free_left;
    } answer_t;

    logic [EC_W-1:0]   wear      [SB_COUNT];
    bit                blk_free  [SB_COUNT];
    logic [TYPE_W-1:0] blk_owner [SB_COUNT];
    bit                blk_full  [SB_COUNT];
    logic [INV_W-1:0]  inv_pages [SB_COUNT];
    int unsigned       free_total;
    logic [THR_W-1:0]  gc_thr;
    answer_t           answers_due[$];
    int                errors;

    function new();
      for (int i = 0; i < SB_COUNT; i++) begin
        wear[i]      = '0;
        blk_free[i]  = 1'b1;
        blk_owner[i] = '0;
        blk_full[i]  = 1'b0;
        inv_pages[i] = '0;
      end
      free_total = SB_COUNT;
      gc_thr     = THR_RESET;
      errors     = 0;
    endfunction

    function int pending();
      return answers_due.size();
    endfunction

    // Mostly an in-use superblock, so that marks, adds and reclaims take effect
    function logic [SB_IDX_W-1:0] busy_index();
      int busy[$];
      for (int i = 0; i < SB_COUNT; i++)
        if (!blk_free[i]) busy.push_back(i);
      if (busy.size() == 0 || $urandom_range(0, 99) < 20)
        return SB_IDX_W'($urandom_range(0, SB_COUNT - 1));
      return SB_IDX_W'(busy[$urandom_range(0, busy.size() - 1)]);
    endfunction

    // Apply one accepted operation word to the table and queue its answer
    function void take_op(logic [MODE_W-1:0] m, logic [SB_IDX_W-1:0] idx,
                          logic [AMT_W-1:0] amt, logic [TYPE_W-1:0] ty);
      answer_t     a;
      int          best;
      int unsigned most;
      int unsigned sum;
      a.chosen = idx;
      a.found  = 1'b0;
      case (m)
        MODE_ADD_INV: begin
          sum = inv_pages[idx] + amt;
          if (sum > INVALID_MAX) sum = INVALID_MAX;
          inv_pages[idx] = INV_W'(sum);
        end
        MODE_MARK_FULL: begin
          if (!blk_free[idx]) blk_full[idx] = 1'b1;
        end
        MODE_OPEN: begin
          if (int'(ty) < TYPE_COUNT) begin
            // least wear wins, lowest index on ties
            best = -1;
            for (int i = 0; i < SB_COUNT; i++)
              if (blk_free[i] && (best < 0 || wear[i] < wear[best])) best = i;
            if (best >= 0) begin
              blk_free[best]  = 1'b0;
              blk_full[best]  = 1'b0;
              blk_owner[best] = ty;
              if (free_total > 0) free_total--;
              a.chosen = SB_IDX_W'(best);
              a.found  = 1'b1;
            end
          end
        end
        MODE_VICTIM: begin
          // needs at least one invalid page; first index wins ties
          most     = 0;
          a.chosen = '0;
          for (int i = 0; i < SB_COUNT; i++)
            if (!blk_free[i] && blk_full[i] && inv_pages[i] > most) begin
              most     = inv_pages[i];
              a.chosen = SB_IDX_W'(i);
              a.found  = 1'b1;
            end
        end
        MODE_RECLAIM: begin
          if (!blk_free[idx]) begin
            if (wear[idx] != EC_MAX) wear[idx] = wear[idx] + 1'b1;
            blk_free[idx]  = 1'b1;
            blk_full[idx]  = 1'b0;
            blk_owner[idx] = '0;
            inv_pages[idx] = '0;
            if (free_total < SB_COUNT) free_total++;
          end
        end
        default: ;
      endcase
      a.gc        = (free_total <= gc_thr);
      a.free_left = FREE_W'(free_total);
      answers_due.push_back(a);
    endfunction

    function void check_answer(logic [SB_IDX_W-1:0] chosen, logic found, logic gc,
                               logic [FREE_W-1:0] free_left);
      answer_t e;
      if (answers_due.size() == 0) begin
        $error("result word with nothing expected: chosen_index %0d free_left %0d",
               chosen, free_left);
        errors++;
        return;
      end
      e = answers_due.pop_front();
      if (chosen !== e.chosen) begin
        $error("chosen_index: expected %0d, got %0d", e.chosen, chosen);
        errors++;
      end
      if (found !== e.found) begin
        $error("found: expected %0d, got %0d", e.found, found);
        errors++;
      end
      if (gc !== e.gc) begin
        $error("gc_needed: expected %0d, got %0d", e.gc, gc);
        errors++;
      end
      if (free_left !== e.free_left) begin
        $error("free_left: expected %0d, got %0d", e.free_left, free_left);
        errors++;
      end
    endfunction
  endclass

  localparam logic [MODE_W-1:0] MODE_SPARE_LO = MODE_W'(5);
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = MODE_W'(7);
  localparam int QUIET_LIMIT  = 5000;
  localparam int RX_HOLD_AT   = 700;
  localparam int RX_HOLD_LEN  = 400;
  localparam int DRAIN_CYCLES = 100;

  logic clk = 1'b0;
  logic rst_n;
  bit   no_idle = 1'b0;

  sbgc_in_if  in_ch();
  sbgc_out_if out_ch();
  sbgc_cfg_if cfg_ch();

  sbgc_scoreboard sb = new();

  superblock_alloc_and_gc_victim_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one operation word, with a random gap first, and note it once taken
  task automatic push_op(input logic [MODE_W-1:0] m, input logic [SB_IDX_W-1:0] idx,
                         input logic [AMT_W-1:0] amt, input logic [TYPE_W-1:0] ty);
    while (!no_idle && $urandom_range(0, 99) < 29) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.mode     <= m;
    in_ch.sb_index <= idx;
    in_ch.amount   <= amt;
    in_ch.sb_type  <= ty;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.take_op(m, idx, amt, ty);
  endtask

  // Stop offering and wait until every expected result word is back
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_thr(input logic [THR_W-1:0] v);
    cfg_ch.valid        <= 1'b1;
    cfg_ch.gc_threshold <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.gc_thr = v;
    cfg_ch.valid <= 1'b0;
  endtask

  // One random operation; reclaim takes the share left below the spare modes
  task automatic random_op(input int p_open, input int p_add, input int p_mark,
                           input int p_vic);
    int                  r;
    int                  ra;
    logic [MODE_W-1:0]   m;
    logic [AMT_W-1:0]    amt;
    r  = $urandom_range(0, 99);
    ra = $urandom_range(0, 9);
    if (r >= 95)                              m = MODE_W'($urandom_range(MODE_SPARE_HI,
                                                                         MODE_SPARE_LO));
    else if (r < p_open)                      m = MODE_OPEN;
    else if (r < p_open + p_add)              m = MODE_ADD_INV;
    else if (r < p_open + p_add + p_mark)     m = MODE_MARK_FULL;
    else if (r < p_open + p_add + p_mark + p_vic) m = MODE_VICTIM;
    else                                      m = MODE_RECLAIM;
    if (ra < 4)      amt = AMT_W'($urandom_range(0, 15));
    else if (ra < 8) amt = AMT_W'($urandom_range(0, INVALID_MAX));
    else             amt = $urandom_range(0, 1) ? AMT_W'(INVALID_MAX) : '0;
    push_op(m, sb.busy_index(), amt, TYPE_W'($urandom_range(0, TYPE_COUNT - 1)));
  endtask

  task automatic run_phase(input logic [THR_W-1:0] thr, input int p_open, input int p_add,
                           input int p_mark, input int p_vic, input int n_ops,
                           input int calm_ops);
    settle();
    write_thr(thr);
    for (int k = 0; k < n_ops; k++) begin
      no_idle = (k < calm_ops);
      random_op(p_open, p_add, p_mark, p_vic);
    end
    no_idle = 1'b0;
  endtask

  // Result side: random stalls plus one long hold-off to back the block up
  initial begin
    int got;
    int hold;
    got  = 0;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        sb.check_answer(out_ch.chosen_index, out_ch.found, out_ch.gc_needed,
                        out_ch.free_left);
        got++;
        if (got == RX_HOLD_AT) hold = RX_HOLD_LEN;
      end
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= no_idle || ($urandom_range(0, 99) >= 29);
      end
    end
  end

  // Watchdog: too long without any word moving on any channel
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("superblock_alloc_and_gc_victim_core_test failed");
    $finish;
  end

  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.mode          = MODE_ADD_INV;
    in_ch.sb_index      = '0;
    in_ch.amount        = '0;
    in_ch.sb_type       = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.gc_threshold = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty victim search, ignored ops on free blocks, opens in order
    push_op(MODE_VICTIM,    6'd9,  12'd0,    2'd0);
    push_op(MODE_ADD_INV,   6'd5,  12'd4095, 2'd0);
    push_op(MODE_MARK_FULL, 6'd5,  12'd0,    2'd0);
    push_op(MODE_RECLAIM,   6'd7,  12'd0,    2'd0);
    push_op(MODE_OPEN,      6'd63, 12'd0,    2'd3);
    push_op(MODE_OPEN,      6'd0,  12'd0,    2'd0);
    push_op(MODE_OPEN,      6'd0,  12'd0,    2'd1);
    push_op(MODE_OPEN,      6'd0,  12'd0,    2'd2);
    // invalid sum saturation, then a tie between two full victims
    push_op(MODE_ADD_INV,   6'd0,  12'd4095, 2'd0);
    push_op(MODE_ADD_INV,   6'd0,  12'd1,    2'd0);
    push_op(MODE_ADD_INV,   6'd1,  12'd4095, 2'd0);
    push_op(MODE_MARK_FULL, 6'd0,  12'd0,    2'd0);
    push_op(MODE_MARK_FULL, 6'd1,  12'd0,    2'd0);
    push_op(MODE_MARK_FULL, 6'd2,  12'd0,    2'd0);
    push_op(MODE_VICTIM,    6'd0,  12'd0,    2'd0);
    // reclaim bumps wear, so the next open skips block 0
    push_op(MODE_RECLAIM,   6'd0,  12'd0,    2'd0);
    push_op(MODE_VICTIM,    6'd0,  12'd0,    2'd0);
    push_op(MODE_OPEN,      6'd0,  12'd0,    2'd1);
    push_op(MODE_ADD_INV,   6'd63, 12'd0,    2'd0);
    push_op(MODE_SPARE_LO,  6'd63, 12'd4095, 2'd3);
    push_op(MODE_SPARE_HI,  6'd0,  12'd0,    2'd0);
    push_op(MODE_RECLAIM,   6'd63, 12'd0,    2'd0);
    // opened block keeps invalid pages it got while free
    push_op(MODE_OPEN,      6'd0,  12'd0,    2'd3);
    push_op(MODE_MARK_FULL, 6'd5,  12'd0,    2'd0);
    push_op(MODE_VICTIM,    6'd0,  12'd0,    2'd0);

    // Random phases: threshold extremes and mixes that drain and refill the pool
    run_phase(THR_W'(64),  45, 20, 12, 10, 300, 0);
    run_phase(THR_W'(0),   20, 30, 15, 15, 300, 0);
    run_phase(THR_W'(127), 10, 25, 15, 15, 300, 150);
    run_phase(THR_W'($urandom_range(1, 63)), 45, 20, 12, 10, 300, 0);
    run_phase(THR_RESET,   20, 30, 15, 15, 300, 0);
    run_phase(THR_W'($urandom_range(0, 127)), 10, 25, 15, 15, 300, 0);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("superblock_alloc_and_gc_victim_core_test passed");
    else
      $display("superblock_alloc_and_gc_victim_core_test failed");
    $finish;
  end

endmodule

@@ filelist.f @@
src/sbgc_pkg.sv
src/sbgc_if.sv
src/sbgc_table.sv
src/sbgc_ctrl.sv
src/superblock_alloc_and_gc_victim_core.sv
src/sbgc_checker.sv
bench/superblock_alloc_and_gc_victim_core_test.sv
